@@ rtl/bmmd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bmmd_pkg;

  // Result target codes.
  localparam logic [3:0] TGT_RAM    = 4'd0;
  localparam logic [3:0] TGT_BASIC  = 4'd1;
  localparam logic [3:0] TGT_KERNAL = 4'd2;
  localparam logic [3:0] TGT_CHAR   = 4'd3;
  localparam logic [3:0] TGT_VIDEO  = 4'd4;
  localparam logic [3:0] TGT_SOUND  = 4'd5;
  localparam logic [3:0] TGT_COLOUR = 4'd6;
  localparam logic [3:0] TGT_CIA1   = 4'd7;
  localparam logic [3:0] TGT_CIA2   = 4'd8;

  // Address map pieces.
  localparam logic [3:0]  IO_PAGE_HI    = 4'hD;  // D000-DFFF
  localparam logic [2:0]  BASIC_HI      = 3'b101; // A000-BFFF
  localparam logic [2:0]  KERNAL_HI     = 3'b111; // E000-FFFF
  localparam logic [1:0]  IO_VIDEO      = 2'd0;
  localparam logic [1:0]  IO_SOUND      = 2'd1;
  localparam logic [1:0]  IO_COLOUR     = 2'd2;
  localparam logic [1:0]  IO_CIA        = 2'd3;
  localparam logic [1:0]  CIA_SEL_1     = 2'd0;
  localparam logic [1:0]  CIA_SEL_2     = 2'd1;
  localparam logic [15:0] PORT_ADDR     = 16'h0001;
  localparam logic [7:0]  PORT_RESET    = 8'h37;

  localparam int MAIN_AW   = 16;
  localparam int COLOUR_AW = 10;

  localparam int CMD_DEPTH_DEF = 2;

  typedef enum logic [1:0] {
    MEM_NONE,
    MEM_MAIN,
    MEM_COLOUR
  } mem_sel_t;

  typedef struct packed {
    logic [3:0]  target;
    logic [15:0] offset;
    logic        is_write;
    logic [7:0]  write_data;
    mem_sel_t    mem_sel;
    logic        drive_bus;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

`default_nettype wire

@@ rtl/bmmd_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bmmd_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  output logic               full,
  input  wire logic [15:0]   address,
  input  wire logic          req_type,
  input  wire logic [7:0]    write_data,
  input  wire bmmd_pkg::fifo_stat_t cmd_stat,
  input  wire logic          clearing,
  output logic               cmd_push,
  output bmmd_pkg::cmd_t     cmd
);
  import bmmd_pkg::*;

  logic [2:0] port_r;
  logic       rd;
  logic       basic_on;
  logic       kernal_on;
  logic       io_on;
  logic       char_on;

  assign rd        = req_type;
  assign basic_on  = (port_r == 3'd3) || (port_r == 3'd7);
  assign kernal_on = (port_r == 3'd2) || (port_r == 3'd3) || (port_r == 3'd6) ||
                     (port_r == 3'd7);
  assign io_on     = (port_r == 3'd5) || (port_r == 3'd6) || (port_r == 3'd7);
  assign char_on   = (port_r == 3'd1) || (port_r == 3'd2) || (port_r == 3'd3);

  assign full     = cmd_stat.full || clearing;
  assign cmd_push = push && !full;

  always_comb begin
    cmd.target     = TGT_RAM;
    cmd.offset     = address;
    cmd.is_write   = !rd;
    cmd.write_data = write_data;
    cmd.mem_sel    = MEM_MAIN;
    cmd.drive_bus  = rd;
    if (address[15:12] != IO_PAGE_HI) begin
      if (rd && (address[15:13] == BASIC_HI) && basic_on) begin
        cmd.target  = TGT_BASIC;
        cmd.offset  = {3'b000, address[12:0]};
        cmd.mem_sel = MEM_NONE;
      end else if (rd && (address[15:13] == KERNAL_HI) && kernal_on) begin
        cmd.target  = TGT_KERNAL;
        cmd.offset  = {3'b000, address[12:0]};
        cmd.mem_sel = MEM_NONE;
      end
    end else if (io_on) begin
      unique case (address[11:10])
        IO_VIDEO: begin
          cmd.target  = TGT_VIDEO;
          cmd.offset  = {10'd0, address[5:0]};
          cmd.mem_sel = MEM_NONE;
        end
        IO_SOUND: begin
          // Sound reads leave the data bus undriven.
          cmd.target    = TGT_SOUND;
          cmd.offset    = {11'd0, address[4:0]};
          cmd.mem_sel   = MEM_NONE;
          cmd.drive_bus = 1'b0;
        end
        IO_COLOUR: begin
          cmd.target  = TGT_COLOUR;
          cmd.offset  = {6'd0, address[9:0]};
          cmd.mem_sel = MEM_COLOUR;
        end
        IO_CIA: begin
          if (address[9:8] == CIA_SEL_1) begin
            cmd.target  = TGT_CIA1;
            cmd.offset  = {12'd0, address[3:0]};
            cmd.mem_sel = MEM_NONE;
          end else if (address[9:8] == CIA_SEL_2) begin
            cmd.target  = TGT_CIA2;
            cmd.offset  = {12'd0, address[3:0]};
            cmd.mem_sel = MEM_NONE;
          end
        end
        default: begin
          cmd.mem_sel = MEM_MAIN;
        end
      endcase
    end else if (char_on && rd) begin
      cmd.target  = TGT_CHAR;
      cmd.offset  = {4'd0, address[11:0]};
      cmd.mem_sel = MEM_NONE;
    end
  end

  // The banking port is shadowed here so that each beat is decoded with the
  // port value left by all earlier beats, without waiting on the RAM.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_r <= PORT_RESET[2:0];
    end else if (cmd_push && !rd && (address == PORT_ADDR)) begin
      port_r <= write_data[2:0];
    end
  end

endmodule

`default_nettype wire

@@ rtl/bmmd_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bmmd_fifo #(
  parameter int DEPTH = bmmd_pkg::CMD_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire bmmd_pkg::cmd_t din,
  input  wire logic           pop,
  output bmmd_pkg::cmd_t      dout,
  output bmmd_pkg::fifo_stat_t stat
);
  import bmmd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push;
  logic          do_pop;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == FULL_CNT);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign dout       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/bmmd_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bmmd_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_valid,
  input  wire bmmd_pkg::cmd_t cmd,
  output logic               cmd_pop,
  output logic               clearing,
  output logic               empty,
  input  wire logic          pop,
  output logic [3:0]         target,
  output logic [15:0]        offset,
  output logic               is_write,
  output logic [7:0]         read_data,
  output logic               read_valid,
  output logic               drive_bus
);
  import bmmd_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ
  } state_t;

  state_t                 state_r;
  logic [MAIN_AW-1:0]     clr_addr_r;
  logic                   out_valid_r;
  mem_sel_t               pend_sel_r;
  logic [3:0]             target_r;
  logic [15:0]            offset_r;
  logic                   is_write_r;
  logic [7:0]             read_data_r;
  logic                   read_valid_r;
  logic                   drive_bus_r;

  logic [7:0]             main_ram [2**MAIN_AW];
  logic [7:0]             colour_ram [2**COLOUR_AW];
  logic [7:0]             main_rdata_r;
  logic [7:0]             colour_rdata_r;

  logic                   issue;
  logic                   main_we;
  logic [MAIN_AW-1:0]     main_waddr;
  logic [7:0]             main_wdata;
  logic                   colour_we;
  logic [COLOUR_AW-1:0]   colour_waddr;
  logic [7:0]             colour_wdata;

  assign clearing = (state_r == ST_CLEAR);
  assign issue    = (state_r == ST_IDLE) && cmd_valid && !out_valid_r;
  assign cmd_pop  = issue;

  always_comb begin
    main_we      = 1'b0;
    main_waddr   = cmd.offset[MAIN_AW-1:0];
    main_wdata   = cmd.write_data;
    colour_we    = 1'b0;
    colour_waddr = cmd.offset[COLOUR_AW-1:0];
    colour_wdata = cmd.write_data;
    if (clearing) begin
      // The clearing pass also seeds the banking port with its reset value.
      main_we      = 1'b1;
      main_waddr   = clr_addr_r;
      main_wdata   = (clr_addr_r == PORT_ADDR[MAIN_AW-1:0]) ? PORT_RESET : 8'h00;
      colour_we    = (clr_addr_r[MAIN_AW-1:COLOUR_AW] == '0);
      colour_waddr = clr_addr_r[COLOUR_AW-1:0];
      colour_wdata = 8'h00;
    end else if (issue && cmd.is_write) begin
      main_we   = (cmd.mem_sel == MEM_MAIN);
      colour_we = (cmd.mem_sel == MEM_COLOUR);
    end
  end

  always_ff @(posedge clk) begin
    if (main_we) begin
      main_ram[main_waddr] <= main_wdata;
    end
    main_rdata_r <= main_ram[cmd.offset[MAIN_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (colour_we) begin
      colour_ram[colour_waddr] <= colour_wdata;
    end
    colour_rdata_r <= colour_ram[cmd.offset[COLOUR_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == '1) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (issue) begin
            target_r     <= cmd.target;
            offset_r     <= cmd.offset;
            is_write_r   <= cmd.is_write;
            read_data_r  <= 8'h00;
            read_valid_r <= 1'b0;
            drive_bus_r  <= cmd.drive_bus;
            pend_sel_r   <= cmd.mem_sel;
            if ((cmd.mem_sel != MEM_NONE) && !cmd.is_write) begin
              state_r <= ST_READ;
            end else begin
              out_valid_r <= 1'b1;
            end
          end
        end
        ST_READ: begin
          // The RAM read issued with the command has landed in the data register.
          read_data_r  <= (pend_sel_r == MEM_COLOUR) ? colour_rdata_r : main_rdata_r;
          read_valid_r <= 1'b1;
          out_valid_r  <= 1'b1;
          state_r      <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign empty      = !out_valid_r;
  assign target     = target_r;
  assign offset     = offset_r;
  assign is_write   = is_write_r;
  assign read_data  = read_data_r;
  assign read_valid = read_valid_r;
  assign drive_bus  = drive_bus_r;

endmodule

`default_nettype wire

@@ rtl/banked_memory_map_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Memory map decoder for a banked 6502-style bus. Each input beat is one CPU
// access; each output beat tells where it went (target code and offset) and,
// for main or colour RAM reads, carries the byte read. After reset the block
// runs a clearing pass over every main RAM address (colour RAM in parallel)
// with full held high; it then takes beats. The front decodes the banking
// port and queues a command; the back performs it against the RAMs into a
// single output register. The back issues no new command until the result in that
// register has been popped; a RAM read also passes through a read state because
// of the registered RAM read port.
module banked_memory_map_decoder #(
  parameter int CMD_DEPTH = bmmd_pkg::CMD_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [15:0] in_address,
  input  wire logic        in_req_type,
  input  wire logic [7:0]  in_write_data,
  output logic             empty,
  input  wire logic        pop,
  output logic [3:0]       out_target,
  output logic [15:0]      out_offset,
  output logic             out_is_write,
  output logic [7:0]       out_read_data,
  output logic             out_read_valid,
  output logic             out_drive_bus
);
  import bmmd_pkg::*;

  cmd_t       front_cmd;
  cmd_t       fifo_cmd;
  fifo_stat_t cmd_stat;
  logic       cmd_push;
  logic       cmd_pop;
  logic       clearing;

  bmmd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .address    (in_address),
    .req_type   (in_req_type),
    .write_data (in_write_data),
    .cmd_stat   (cmd_stat),
    .clearing   (clearing),
    .cmd_push   (cmd_push),
    .cmd        (front_cmd)
  );

  bmmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (front_cmd),
    .pop   (cmd_pop),
    .dout  (fifo_cmd),
    .stat  (cmd_stat)
  );

  bmmd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (!cmd_stat.empty),
    .cmd        (fifo_cmd),
    .cmd_pop    (cmd_pop),
    .clearing   (clearing),
    .empty      (empty),
    .pop        (pop),
    .target     (out_target),
    .offset     (out_offset),
    .is_write   (out_is_write),
    .read_data  (out_read_data),
    .read_valid (out_read_valid),
    .drive_bus  (out_drive_bus)
  );

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import bmmd_pkg::*;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;
  localparam int   RANDOM_ACCESSES = 1800;
  localparam int   STALL_LIMIT     = 300000;  // covers the RAM clearing pass after reset
  localparam int   HOLD_OFF_CYCLES = 300;

  typedef struct packed {
    logic [15:0] addr;
    logic        rd;
    logic [7:0]  data;
    logic        drain;  // offer only once every earlier result is back
  } access_t;

  typedef struct packed {
    logic [3:0]  target;
    logic [15:0] offset;
    logic        is_write;
    logic [7:0]  read_data;
    logic        read_valid;
    logic        drive_bus;
  } route_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic [15:0] in_address = '0;
  logic        in_req_type = 1'b0;
  logic [7:0]  in_write_data = '0;
  logic        full, empty;
  logic [3:0]  out_target;
  logic [15:0] out_offset;
  logic        out_is_write, out_read_valid, out_drive_bus;
  logic [7:0]  out_read_data;

  logic [7:0] main_mem [0:65535];
  logic [7:0] colour_mem [0:1023];

  access_t pending_accesses[$];
  route_t  expected_routes[$];
  logic [15:0] written_addrs[$];

  int sent_cnt = 0;
  int got_cnt = 0;
  int errors = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int idle_cycles = 0;
  int target_hits [0:15];

  banked_memory_map_decoder dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_address    (in_address),
    .in_req_type   (in_req_type),
    .in_write_data (in_write_data),
    .empty         (empty),
    .pop           (pop),
    .out_target    (out_target),
    .out_offset    (out_offset),
    .out_is_write  (out_is_write),
    .out_read_data (out_read_data),
    .out_read_valid(out_read_valid),
    .out_drive_bus (out_drive_bus)
  );

  always #2 clk = ~clk;

  // Routes one access against the current banking and updates the RAM copies.
  function automatic route_t decode_access(access_t a);
    route_t     r;
    logic [2:0] bank;
    logic       basic_vis, kernal_vis, io_vis, char_vis, plain;
    logic [9:0] cidx;
    bank = main_mem[PORT_ADDR][2:0];
    // KERNAL shows for 2,3,6,7; BASIC for 3,7; I/O for 5,6,7; char ROM for 1,2,3.
    basic_vis  = bank[1] & bank[0];
    kernal_vis = bank[1];
    io_vis     = bank[2] & (bank[1] | bank[0]);
    char_vis   = ~bank[2] & (bank[1] | bank[0]);
    r = '0;
    plain = 1'b0;
    cidx = a.addr[9:0];
    if (a.addr < 16'hD000 || a.addr > 16'hDFFF) begin
      if (a.rd && a.addr >= 16'hA000 && a.addr < 16'hC000 && basic_vis) begin
        r.target = TGT_BASIC;
        r.offset = a.addr - 16'hA000;
        r.drive_bus = 1'b1;
      end else if (a.rd && a.addr >= 16'hE000 && kernal_vis) begin
        r.target = TGT_KERNAL;
        r.offset = a.addr - 16'hE000;
        r.drive_bus = 1'b1;
      end else begin
        plain = 1'b1;
      end
    end else if (io_vis) begin
      r.is_write = ~a.rd;
      r.drive_bus = a.rd;
      case (a.addr[11:10])
        IO_VIDEO: begin
          r.target = TGT_VIDEO;
          r.offset = {10'd0, a.addr[5:0]};
        end
        IO_SOUND: begin
          r.target = TGT_SOUND;
          r.offset = {11'd0, a.addr[4:0]};
          r.drive_bus = 1'b0;
        end
        IO_COLOUR: begin
          r.target = TGT_COLOUR;
          r.offset = {6'd0, cidx};
          if (a.rd) begin
            r.read_data = colour_mem[cidx];
            r.read_valid = 1'b1;
          end else begin
            colour_mem[cidx] = a.data;
          end
        end
        default: begin
          r.offset = {12'd0, a.addr[3:0]};
          if (a.addr[9:8] == CIA_SEL_1) r.target = TGT_CIA1;
          else if (a.addr[9:8] == CIA_SEL_2) r.target = TGT_CIA2;
          else plain = 1'b1;
        end
      endcase
    end else if (char_vis && a.rd) begin
      r.target = TGT_CHAR;
      r.offset = a.addr - 16'hD000;
      r.drive_bus = 1'b1;
    end else begin
      plain = 1'b1;
    end
    if (plain) begin
      r = '0;
      r.target = TGT_RAM;
      r.offset = a.addr;
      if (a.rd) begin
        r.read_data = main_mem[a.addr];
        r.read_valid = 1'b1;
        r.drive_bus = 1'b1;
      end else begin
        main_mem[a.addr] = a.data;
        r.is_write = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic add_access(logic [15:0] addr, logic rd, logic [7:0] data, logic drain);
    access_t a;
    a.addr = addr;
    a.rd = rd;
    a.data = data;
    a.drain = drain;
    pending_accesses.push_back(a);
    if (!rd) begin
      written_addrs.push_back(addr);
      if (written_addrs.size() > 128) void'(written_addrs.pop_front());
    end
  endtask

  function automatic logic [15:0] pick_address(int zone);
    case (zone)
      0: return 16'hA000 + 16'($urandom_range(16'h1FFF));
      1: return 16'hE000 + 16'($urandom_range(16'h1FFF));
      2: return 16'hD000 + 16'($urandom_range(16'h03FF));
      3: return 16'hD400 + 16'($urandom_range(16'h03FF));
      4: return 16'hD800 + 16'($urandom_range(16'h03FF));
      5: return 16'hDC00 + 16'($urandom_range(16'h00FF));
      6: return 16'hDD00 + 16'($urandom_range(16'h00FF));
      7: return 16'hDE00 + 16'($urandom_range(16'h01FF));
      8: return 16'($urandom_range(16'h03FF));
      default: return 16'($urandom);
    endcase
  endfunction

  task compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  // Sender: holds a beat until it is taken, then picks the next one or idles.
  always @(posedge clk) begin : drive_accesses
    logic    offer;
    access_t head;
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      offer = push;
      if (push && !full) begin
        expected_routes.push_back(decode_access(pending_accesses.pop_front()));
        sent_cnt++;
        offer = 1'b0;
      end
      head = '0;
      if (!(push && full)) begin
        if (pending_accesses.size() == 0) begin
          offer = 1'b0;
        end else begin
          head = pending_accesses[0];
          if (head.drain && expected_routes.size() != 0) offer = 1'b0;
          else offer = (sent_cnt >= 400 && sent_cnt < 700) || ($urandom_range(99) >= 30);
        end
        if (offer) begin
          in_address <= head.addr;
          in_req_type <= head.rd;
          in_write_data <= head.data;
        end
      end
      push <= offer;
    end
  end

  // Receiver: checks each result beat and stalls at random or for one long stretch.
  always @(posedge clk) begin : check_routes
    route_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        got_cnt++;
        target_hits[out_target]++;
        if (expected_routes.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected: target %0d offset 0x%0h",
                   $time, out_target, out_offset);
        end else begin
          want = expected_routes.pop_front();
          compare_field("target", want.target, out_target);
          compare_field("offset", want.offset, out_offset);
          compare_field("is_write", want.is_write, out_is_write);
          compare_field("read_data", want.read_data, out_read_data);
          compare_field("read_valid", want.read_valid, out_read_valid);
          compare_field("drive_bus", want.drive_bus, out_drive_bus);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (!hold_done && got_cnt >= 1000) begin
        hold_done = 1'b1;
        hold_left = HOLD_OFF_CYCLES - 1;
        pop <= 1'b0;
      end else begin
        pop <= (got_cnt >= 400 && got_cnt < 700) || ($urandom_range(99) >= 30);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles = 0;
    end else if ((push && !full) || (pop && !empty)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin : run
    int n, zone, burst;
    logic rd;
    bit mid_drain;
    for (int i = 0; i < 65536; i++) main_mem[i] = 8'h00;
    for (int i = 0; i < 1024; i++) colour_mem[i] = 8'h00;
    for (int i = 0; i < 16; i++) target_hits[i] = 0;
    main_mem[PORT_ADDR] = PORT_RESET;

    // Default banking: BASIC, KERNAL and I/O visible.
    add_access(16'hA000, REQ_READ, 8'h00, 1'b0);
    add_access(16'hFFFF, REQ_READ, 8'hFF, 1'b0);
    add_access(16'hFFFF, REQ_WRITE, 8'hFF, 1'b0);
    add_access(16'hD000, REQ_READ, 8'h00, 1'b0);
    add_access(16'hD43F, REQ_READ, 8'h00, 1'b0);
    add_access(16'hD800, REQ_WRITE, 8'hA5, 1'b0);
    add_access(16'hD800, REQ_READ, 8'h00, 1'b0);
    add_access(16'hDBFF, REQ_WRITE, 8'h5A, 1'b0);
    add_access(16'hDBFF, REQ_READ, 8'h00, 1'b0);
    add_access(16'hDC1F, REQ_READ, 8'h00, 1'b0);
    add_access(16'hDDF0, REQ_WRITE, 8'h81, 1'b0);
    add_access(16'hDE00, REQ_WRITE, 8'h77, 1'b0);
    add_access(16'hDE00, REQ_READ, 8'h00, 1'b0);
    add_access(16'hA000, REQ_WRITE, 8'h3C, 1'b0);
    // Character ROM banked in, then everything RAM.
    add_access(PORT_ADDR, REQ_WRITE, 8'h33, 1'b0);
    add_access(16'hD123, REQ_READ, 8'h00, 1'b0);
    add_access(16'hD123, REQ_WRITE, 8'hC3, 1'b0);
    add_access(PORT_ADDR, REQ_WRITE, 8'h00, 1'b0);
    add_access(16'hD123, REQ_READ, 8'h00, 1'b0);
    add_access(16'hA000, REQ_READ, 8'h00, 1'b0);
    add_access(16'hFFFF, REQ_READ, 8'h00, 1'b0);
    add_access(16'h0000, REQ_READ, 8'h00, 1'b0);
    add_access(PORT_ADDR, REQ_WRITE, 8'hFF, 1'b0);
    add_access(PORT_ADDR, REQ_READ, 8'h00, 1'b0);

    // Random part: mostly a banking change followed by a burst into banked regions.
    n = 0;
    mid_drain = 1'b0;
    while (n < RANDOM_ACCESSES) begin
      if ($urandom_range(99) < 75) begin
        add_access(PORT_ADDR, REQ_WRITE, 8'($urandom), n == 0);
        n++;
      end
      burst = $urandom_range(4, 14);
      repeat (burst) begin
        zone = $urandom_range(11);
        rd = $urandom_range(99) < 55;
        if (zone >= 10 && written_addrs.size() != 0) begin
          add_access(written_addrs[$urandom_range(written_addrs.size() - 1)], REQ_READ,
                     8'($urandom), n == 0);
        end else begin
          add_access(pick_address(zone), rd, 8'($urandom), n == 0 || (n >= 900 && !mid_drain));
          if (n >= 900) mid_drain = 1'b1;
        end
        n++;
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_accesses.size() != 0) @(posedge clk);
    while (expected_routes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Checked %0d result beats: ram %0d, basic %0d, kernal %0d, char %0d, video %0d,",
             got_cnt, target_hits[TGT_RAM], target_hits[TGT_BASIC], target_hits[TGT_KERNAL],
             target_hits[TGT_CHAR], target_hits[TGT_VIDEO]);
    $display("  sound %0d, colour %0d, cia1 %0d, cia2 %0d; with random banking, stalls and drains",
             target_hits[TGT_SOUND], target_hits[TGT_COLOUR], target_hits[TGT_CIA1],
             target_hits[TGT_CIA2]);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ banked_memory_map_decoder.f @@
rtl/bmmd_pkg.sv
rtl/bmmd_front.sv
rtl/bmmd_fifo.sv
rtl/bmmd_back.sv
rtl/banked_memory_map_decoder.sv
tb/sv/testbench.sv
